[hw/rtl/fet_pkg.sv]
// shared types, constants and helpers of the escape-time fractal pixel engine
`default_nettype none

package fet_pkg;

  // fixed point format and frame geometry
  localparam int FRACTION_BITS = 28;
  localparam int FRAME_WIDTH   = 1024;
  localparam int FRAME_HEIGHT  = 1024;

  // field widths
  localparam int PIX_W    = 12;
  localparam int CNT_W    = 12;
  localparam int STRIDE_W = 16;
  localparam int OFS_W    = 24;
  localparam int VAL_W    = 8;
  localparam int CFG_W    = 32;
  localparam int REG_IDX_W = 3;

  // squares and cross product after the fraction shift, and the update adder
  localparam int XW = 66 - FRACTION_BITS;
  localparam int UW = XW + 2;

  // byte offset x*4 + y*stride
  localparam int PROD_W = PIX_W + STRIDE_W;
  localparam int BASE_W = PROD_W + 1;
  localparam logic [BASE_W-1:0] FRAME_BYTES = BASE_W'(FRAME_WIDTH * FRAME_HEIGHT * 4);

  localparam logic signed [UW-1:0] ESC_LIMIT = UW'(4 << FRACTION_BITS);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_JULIA_RE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_JULIA_IM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE   = 3'd4;

  // reset values
  localparam logic [CNT_W-1:0]    MAX_ITER_RST = 12'd64;
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 16'd4096;

  typedef enum logic [1:0] {
    MODE_MANDEL = 2'd0,
    MODE_SHIP   = 2'd1,
    MODE_JULIA  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CNT_W-1:0]    max_iter;
    logic [31:0]         julia_re;
    logic [31:0]         julia_im;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escape;
  } status_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [UW-1:0] v);
    logic [UW-32:0] top;
    top = v[UW-1:31];
    if ((&top) || (~|top)) begin
      return v[31:0];
    end else if (v[UW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fet_regs.sv]
// configuration register file of the fractal pixel engine
`default_nettype none

module fet_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fet_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fet_pkg::CFG_W-1:0]      cfg_data_i,
  output fet_pkg::cfg_t                       cfg_o
);

  fet_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fet_pkg::REG_MODE:     cfg_d.mode     = cfg_data_i[1:0];
        fet_pkg::REG_MAX_ITER: cfg_d.max_iter = cfg_data_i[fet_pkg::CNT_W-1:0];
        fet_pkg::REG_JULIA_RE: cfg_d.julia_re = cfg_data_i;
        fet_pkg::REG_JULIA_IM: cfg_d.julia_im = cfg_data_i;
        fet_pkg::REG_STRIDE:   cfg_d.stride   = cfg_data_i[fet_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= fet_pkg::MODE_MANDEL;
      cfg_q.max_iter <= fet_pkg::MAX_ITER_RST;
      cfg_q.julia_re <= '0;
      cfg_q.julia_im <= '0;
      cfg_q.stride   <= fet_pkg::STRIDE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/fet_ctrl.sv]
// controller state machine: item intake, iteration sequencing, result register handshake
`default_nettype none

module fet_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire fet_pkg::status_t sts_i,
  output fet_pkg::cmd_t   cmd_o
);

  fet_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fet_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fet_pkg::ST_MUL;
        end
      end
      fet_pkg::ST_MUL: begin
        if (sts_i.limit_hit) begin
          state_d = fet_pkg::ST_FIN;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = fet_pkg::ST_UPD;
        end
      end
      fet_pkg::ST_UPD: begin
        if (sts_i.escape) begin
          state_d = fet_pkg::ST_FIN;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = fet_pkg::ST_MUL;
        end
      end
      fet_pkg::ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = fet_pkg::ST_IDLE;
        end
      end
      default: state_d = fet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fet_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/fet_dp.sv]
// datapath: point registers, square and cross multipliers, update adders, result register
`default_nettype none

module fet_dp (
  input  wire logic                          clk_i,
  input  wire fet_pkg::cfg_t                 cfg_i,
  input  wire fet_pkg::cmd_t                 cmd_i,
  output fet_pkg::status_t                   sts_o,
  input  wire logic [fet_pkg::PIX_W-1:0]     pixel_x_i,
  input  wire logic [fet_pkg::PIX_W-1:0]     pixel_y_i,
  input  wire logic signed [31:0]            point_re_i,
  input  wire logic signed [31:0]            point_im_i,
  output logic                               write_enable_o,
  output logic [fet_pkg::CNT_W-1:0]          iteration_count_o,
  output logic [fet_pkg::OFS_W-1:0]          first_offset_o,
  output logic [fet_pkg::VAL_W-1:0]          first_value_o,
  output logic [fet_pkg::OFS_W-1:0]          second_offset_o,
  output logic [fet_pkg::VAL_W-1:0]          second_value_o
);

  localparam int XW     = fet_pkg::XW;
  localparam int UW     = fet_pkg::UW;
  localparam int BASE_W = fet_pkg::BASE_W;

  logic ship, julia;
  assign ship  = (cfg_i.mode == fet_pkg::MODE_SHIP);
  assign julia = (cfg_i.mode == fet_pkg::MODE_JULIA);

  // iteration state
  logic signed [31:0]          re_q, re_d, im_q, im_d, add_re_q, add_re_d;
  logic signed [33:0]          add_im_q, add_im_d;
  logic [BASE_W-1:0]           base_q, base_d;
  logic [fet_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic signed [XW-1:0]        sq_re_q, sq_im_q, cross_q;

  // start values
  logic [fet_pkg::PROD_W-1:0]  row_ofs;
  logic signed [33:0]          pim_x;

  assign row_ofs = pixel_y_i * cfg_i.stride;
  assign pim_x   = 34'(point_im_i);

  // multiplier stage
  logic signed [63:0] p_rr, p_ii, p_ri;
  assign p_rr = re_q * re_q;
  assign p_ii = im_q * im_q;
  assign p_ri = re_q * im_q;

  // update stage
  logic signed [UW-1:0] mag, re_sum, im_sum;
  logic signed [XW-1:0] cross_abs;

  assign mag       = UW'(sq_re_q) + UW'(sq_im_q);
  assign cross_abs = (ship && cross_q[XW-1]) ? -cross_q : cross_q;
  assign re_sum    = UW'(sq_re_q) - UW'(sq_im_q) + UW'(add_re_q);
  assign im_sum    = UW'(cross_abs) + UW'(add_im_q);

  assign sts_o.escape    = (mag > fet_pkg::ESC_LIMIT);
  assign sts_o.limit_hit = (cnt_q >= cfg_i.max_iter);

  always_comb begin
    re_d     = re_q;
    im_d     = im_q;
    add_re_d = add_re_q;
    add_im_d = add_im_q;
    base_d   = base_q;
    cnt_d    = cnt_q;
    if (cmd_i.load) begin
      base_d = BASE_W'(row_ofs) + BASE_W'({pixel_x_i, 2'b00});
      cnt_d  = '0;
      if (julia) begin
        re_d     = point_re_i;
        im_d     = point_im_i;
        add_re_d = $signed(cfg_i.julia_re);
        add_im_d = 34'($signed(cfg_i.julia_im));
      end else begin
        re_d     = '0;
        im_d     = '0;
        add_re_d = point_re_i;
        add_im_d = ship ? -(pim_x <<< 1) : pim_x;
      end
    end else if (cmd_i.upd) begin
      re_d  = fet_pkg::sat32(re_sum);
      im_d  = fet_pkg::sat32(im_sum);
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q     <= re_d;
    im_q     <= im_d;
    add_re_q <= add_re_d;
    add_im_q <= add_im_d;
    base_q   <= base_d;
    cnt_q    <= cnt_d;
    if (cmd_i.mul) begin
      sq_re_q <= XW'(p_rr >>> fet_pkg::FRACTION_BITS);
      sq_im_q <= XW'(p_ii >>> fet_pkg::FRACTION_BITS);
      cross_q <= XW'(p_ri >>> (fet_pkg::FRACTION_BITS - 1));
    end
  end

  // result formatting
  logic                        we;
  logic [fet_pkg::VAL_W-1:0]   v6;
  logic [1:0]                  lane1, lane2;

  assign we    = (cnt_q < cfg_i.max_iter) && (base_q < fet_pkg::FRAME_BYTES);
  assign v6    = {cnt_q[5:0], 2'b00} + {cnt_q[6:0], 1'b0};
  assign lane1 = julia ? 2'd1 : 2'd0;
  assign lane2 = (julia || ship) ? 2'd2 : 2'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      write_enable_o    <= we;
      iteration_count_o <= cnt_q;
      if (we) begin
        first_offset_o  <= fet_pkg::OFS_W'(base_q + BASE_W'(lane1));
        first_value_o   <= v6;
        second_offset_o <= fet_pkg::OFS_W'(base_q + BASE_W'(lane2));
        second_value_o  <= ship ? (v6 & 8'h7f) : (v6 & 8'h3f);
      end else begin
        first_offset_o  <= '0;
        first_value_o   <= '0;
        second_offset_o <= '0;
        second_value_o  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fractal_escape_time_pixel.sv]
// top level of the escape-time fractal pixel engine
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_stall_o   pixel_x, pixel_y, point_re, point_im
//   result    out        out_valid_o/out_stall_i write_enable .. second_value
//   config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// an item passes through intake, one multiply and one update step per iteration,
// the last check (the limit is checked in the multiply step, an escape in the
// update step), then the result load step
// reset clears the state machine and result valid and presets the config registers
// a new item is taken while the result register still waits for its transfer
// a stalled result holds the next item in its result load cycle
`default_nettype none

module fractal_escape_time_pixel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fet_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fet_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fet_pkg::PIX_W-1:0]     pixel_x_i,
  input  wire logic [fet_pkg::PIX_W-1:0]     pixel_y_i,
  input  wire logic signed [31:0]            point_re_i,
  input  wire logic signed [31:0]            point_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               write_enable_o,
  output logic [fet_pkg::CNT_W-1:0]          iteration_count_o,
  output logic [fet_pkg::OFS_W-1:0]          first_offset_o,
  output logic [fet_pkg::VAL_W-1:0]          first_value_o,
  output logic [fet_pkg::OFS_W-1:0]          second_offset_o,
  output logic [fet_pkg::VAL_W-1:0]          second_value_o
);

  fet_pkg::cfg_t    cfg;
  fet_pkg::cmd_t    cmd;
  fet_pkg::status_t sts;

  fet_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fet_dp u_dp (
    .clk_i             (clk_i),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .point_re_i        (point_re_i),
    .point_im_i        (point_im_i),
    .write_enable_o    (write_enable_o),
    .iteration_count_o (iteration_count_o),
    .first_offset_o    (first_offset_o),
    .first_value_o     (first_value_o),
    .second_offset_o   (second_offset_o),
    .second_value_o    (second_value_o)
  );

endmodule

`default_nettype wire
